// File: src/utf8cp_pkg.sv
// Shared types and constants for the UTF-8 to code point decoder.
package utf8cp_pkg;

  localparam int unsigned MAX_RES   = 4;
  localparam int unsigned RES_DEPTH = 8;
  localparam int unsigned RES_PTR_W = $clog2(RES_DEPTH);
  localparam int unsigned RES_CNT_W = $clog2(RES_DEPTH + 1);

  localparam logic [7:0] LEAD4_MASK = 8'hF0;
  localparam logic [7:0] LEAD3_MASK = 8'hE0;
  localparam logic [7:0] LEAD2_MASK = 8'hC0;

  typedef struct packed {
    logic [7:0] text_byte;
    logic       final_byte;
  } in_t;

  typedef struct packed {
    logic [20:0] code_point;
    logic        char_valid;
    logic        text_done;
  } out_t;

endpackage

// File: src/utf8cp_decode.sv
// Combinational decode of a four-byte window into up to four packed results.
module utf8cp_decode
  import utf8cp_pkg::*;
(
  input  logic [3:0][7:0] win_i,
  input  logic [2:0]      num_i,
  input  logic            last_i,
  output out_t [3:0]      res_o,
  output logic [2:0]      res_cnt_o
);

  always_comb begin
    logic [6:0][7:0] ext;
    logic [7:0]      b;
    logic [7:0]      b1;
    logic [7:0]      b2;
    logic [7:0]      b3;
    logic            ascii;
    logic            lead4;
    logic            lead3;
    logic            lead2;
    logic [2:0]      need;
    logic [20:0]     cp;
    logic            active;
    logic            trunc;
    logic            alive;
    logic [2:0]      cnt;
    logic [2:0]      last_idx;

    ext      = {24'h000000, win_i};
    alive    = 1'b1;
    cnt      = 3'd0;
    res_o    = '0;
    for (int p = 0; p < 4; p++) begin
      b      = ext[p];
      b1     = ext[p + 1];
      b2     = ext[p + 2];
      b3     = ext[p + 3];
      ascii  = (b[7] == 1'b0) && (b != 8'h00);
      lead4  = (b & LEAD4_MASK) == LEAD4_MASK;
      lead3  = ((b & LEAD3_MASK) == LEAD3_MASK) && !lead4;
      lead2  = ((b & LEAD2_MASK) == LEAD2_MASK) && !lead4 && !lead3;
      need   = lead4 ? 3'd3 : (lead3 ? 3'd2 : (lead2 ? 3'd1 : 3'd0));
      if (lead4) begin
        cp = {b[2:0], b1[5:0], b2[5:0], b3[5:0]};
      end else if (lead3) begin
        cp = {5'd0, b[3:0], b1[5:0], b2[5:0]};
      end else if (lead2) begin
        cp = {10'd0, b[4:0], b1[5:0]};
      end else begin
        cp = {13'd0, b};
      end
      if (last_i) begin
        active = 3'(p) < num_i;
      end else begin
        active = (p == 0) && (num_i == 3'd4);
      end
      trunc = (lead4 || lead3 || lead2) && ((3'(p) + need) >= num_i);
      if (active && trunc) begin
        alive = 1'b0;
      end
      if (alive && active && (ascii || lead4 || lead3 || lead2)) begin
        res_o[cnt[1:0]].code_point = cp;
        res_o[cnt[1:0]].char_valid = 1'b1;
        res_o[cnt[1:0]].text_done  = 1'b0;
        cnt = cnt + 3'd1;
      end
    end
    last_idx = cnt - 3'd1;
    if (last_i) begin
      if (cnt == 3'd0) begin
        res_o[0].code_point = '0;
        res_o[0].char_valid = 1'b0;
        res_o[0].text_done  = 1'b1;
        cnt = 3'd1;
      end else begin
        res_o[last_idx[1:0]].text_done = 1'b1;
      end
    end
    res_cnt_o = cnt;
  end

endmodule

// File: src/utf8_to_codepoint_decoder.sv
// Top level of the UTF-8 to code point decoder with its window and result queue.
//
// The input channel takes one text byte per transaction, with final_byte set on
// the last byte of a text. The output channel gives one code point per
// transaction, with char_valid and text_done flags.
// Each byte position is decoded from the byte and the three bytes after it, so a
// character is decoded once three more bytes have arrived and is written to the
// result queue by the transaction that completes its window. A final byte drains
// the window into up to four results, which leave one per cycle while the receiver
// is ready. Throughput is one byte per cycle while in_ready_o is high, set by the
// single-pass decode between the window registers and an eight-entry result queue.
// The input is ready while at most four results wait in the queue, so a receiver
// stall fills the queue and then holds off the sender; nothing is dropped.
// Reset empties the window and the queue; the block is ready as soon as reset is
// released.
module utf8_to_codepoint_decoder
  import utf8cp_pkg::*;
(
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  in_t  in_data_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output out_t out_data_o
);

  logic [2:0][7:0]       win_q, win_d;
  logic [1:0]            wcnt_q, wcnt_d;
  logic [3:0][7:0]       dec_win;
  logic [2:0]            dec_num;
  out_t [3:0]            dec_res;
  logic [2:0]            dec_cnt;
  logic                  in_fire;
  logic                  out_fire;
  logic [2:0]            push_cnt;
  out_t                  res_q [RES_DEPTH];
  logic [RES_PTR_W-1:0]  wr_q, wr_d;
  logic [RES_PTR_W-1:0]  rd_q, rd_d;
  logic [RES_CNT_W-1:0]  fill_q, fill_d;

  always_comb begin
    dec_win          = {8'h00, win_q};
    dec_win[wcnt_q]  = in_data_i.text_byte;
    dec_num          = {1'b0, wcnt_q} + 3'd1;
  end

  utf8cp_decode u_decode (
    .win_i     (dec_win),
    .num_i     (dec_num),
    .last_i    (in_data_i.final_byte),
    .res_o     (dec_res),
    .res_cnt_o (dec_cnt)
  );

  assign in_ready_o  = fill_q <= RES_CNT_W'(RES_DEPTH - MAX_RES);
  assign in_fire     = in_valid_i && in_ready_o;
  assign out_valid_o = fill_q != '0;
  assign out_fire    = out_valid_o && out_ready_i;
  assign out_data_o  = res_q[rd_q];
  assign push_cnt    = in_fire ? dec_cnt : 3'd0;

  always_comb begin
    win_d  = win_q;
    wcnt_d = wcnt_q;
    if (in_fire) begin
      if (in_data_i.final_byte) begin
        win_d  = '0;
        wcnt_d = 2'd0;
      end else if (wcnt_q == 2'd3) begin
        win_d[0] = win_q[1];
        win_d[1] = win_q[2];
        win_d[2] = in_data_i.text_byte;
      end else begin
        win_d[wcnt_q] = in_data_i.text_byte;
        wcnt_d        = wcnt_q + 2'd1;
      end
    end
    wr_d   = wr_q + RES_PTR_W'(push_cnt);
    rd_d   = rd_q + RES_PTR_W'(out_fire);
    fill_d = fill_q + RES_CNT_W'(push_cnt) - RES_CNT_W'(out_fire);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      win_q  <= '0;
      wcnt_q <= 2'd0;
      wr_q   <= '0;
      rd_q   <= '0;
      fill_q <= '0;
    end else begin
      win_q  <= win_d;
      wcnt_q <= wcnt_d;
      wr_q   <= wr_d;
      rd_q   <= rd_d;
      fill_q <= fill_d;
    end
  end

  always_ff @(posedge clk_i) begin
    for (int j = 0; j < MAX_RES; j++) begin
      if (in_fire && (3'(j) < dec_cnt)) begin
        res_q[wr_q + RES_PTR_W'(j)] <= dec_res[j];
      end
    end
  end

endmodule
